>>> rtl/line_rasterizer_assert.svh
// assertion macros for the line rasterizer
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lr_pkg.sv
// shared types and constants for the line rasterizer
package lr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int DT_BITS     = COORD_BITS + 3;
	// depth must be a power of two, the pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	// one classified command, set up in the front and carried out in the back
	typedef struct packed {
		op_t                        op;
		logic [COORD_BITS-1:0]      start_x;
		logic [COORD_BITS-1:0]      start_y;
		logic [COORD_BITS-1:0]      delta_x;
		logic [COORD_BITS-1:0]      delta_y;
		logic                       x_negative;
		logic                       y_negative;
		logic                       y_major;
		logic signed [DT_BITS-1:0]  decision;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/line_rasterizer.sv
// top level of the bresenham line rasterizer
//
//  channel  handshake             payload
//  req      req_valid/req_stall   op, start_x, start_y, end_x, end_y
//  rsp      rsp_valid/rsp_stall   pixel_x, pixel_y, pixel_valid, last_pixel
//
// one item per clock sustained while rsp_stall is low, one result per item
// a taken item goes to the outputs through the queue write, then the result register
// the queue holds four items; req_stall rises only when it is full
// rsp_stall holds the result register and, once the queue fills, the request side
// reset is immediate, no clearing pass
module line_rasterizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          op,
	input  logic [lr_pkg::COORD_BITS-1:0] start_x,
	input  logic [lr_pkg::COORD_BITS-1:0] start_y,
	input  logic [lr_pkg::COORD_BITS-1:0] end_x,
	input  logic [lr_pkg::COORD_BITS-1:0] end_y,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [lr_pkg::COORD_BITS-1:0] pixel_x,
	output logic [lr_pkg::COORD_BITS-1:0] pixel_y,
	output logic                          pixel_valid,
	output logic                          last_pixel
);
	import lr_pkg::*;

	`include "line_rasterizer_assert.svh"

	// front to queue
	logic      q_push;
	cmd_t      front_cmd;
	// queue to back
	logic      q_pop;
	cmd_t      back_cmd;
	q_status_t q_stat;

	// front: classifies items, works out deltas, directions, major axis and decision term
	lr_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_cmd     (front_cmd)
	);

	// decoupling queue so each side can stall on its own
	lr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (front_cmd),
		.pop     (q_pop),
		.cmd_out (back_cmd),
		.stat    (q_stat)
	);

	// back: holds the line state, steps one pixel per command, owns the result register
	lr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_cmd       (back_cmd),
		.q_stat      (q_stat),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_valid (pixel_valid),
		.last_pixel  (last_pixel)
	);

	// a step with no line running gives an all-zero result
	`LR_ASSERT_NOW(a_idle_zero, rsp_valid && !pixel_valid,
		!last_pixel && pixel_x == '0 && pixel_y == '0, "idle result not zero")
	// queue can never read full and empty at once
	`LR_ASSERT_NOW(a_q_count, q_stat.full, !q_stat.empty, "queue full and empty together")
	// the back part never pops an empty queue
	`LR_ASSERT_NOW(a_pop_ok, q_pop, !q_stat.empty, "pop from empty queue")

endmodule

>>> rtl/lr_front.sv
// front part: takes items and works out the line setup for start items
module lr_front (
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          op,
	input  logic [lr_pkg::COORD_BITS-1:0] start_x,
	input  logic [lr_pkg::COORD_BITS-1:0] start_y,
	input  logic [lr_pkg::COORD_BITS-1:0] end_x,
	input  logic [lr_pkg::COORD_BITS-1:0] end_y,
	input  lr_pkg::q_status_t             q_stat,
	output logic                          q_push,
	output lr_pkg::cmd_t                  q_cmd
);
	import lr_pkg::*;

	logic [COORD_BITS-1:0] dx, dy, major, minor;
	logic                  xn, yn, ym;

	always_comb begin
		xn    = end_x < start_x;
		yn    = end_y < start_y;
		dx    = xn ? (start_x - end_x) : (end_x - start_x);
		dy    = yn ? (start_y - end_y) : (end_y - start_y);
		ym    = dy > dx;
		major = ym ? dy : dx;
		minor = ym ? dx : dy;
	end

	always_comb begin
		q_cmd.op         = op_t'(op);
		q_cmd.start_x    = start_x;
		q_cmd.start_y    = start_y;
		q_cmd.delta_x    = dx;
		q_cmd.delta_y    = dy;
		q_cmd.x_negative = xn;
		q_cmd.y_negative = yn;
		q_cmd.y_major    = ym;
		// 2*minor - major
		q_cmd.decision   = {2'b00, minor, 1'b0} - {3'b000, major};
	end

	assign req_stall = q_stat.full;
	assign q_push    = req_valid && !q_stat.full;

endmodule

>>> rtl/lr_queue.sv
// short command queue between the front and back parts
module lr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lr_pkg::cmd_t      cmd_in,
	input  logic              pop,
	output lr_pkg::cmd_t      cmd_out,
	output lr_pkg::q_status_t stat
);
	import lr_pkg::*;

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cmd_in;
	end

	assign cmd_out    = mem_q[rd_ptr_q];
	assign stat.full  = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign stat.empty = count_q == '0;

endmodule

>>> rtl/lr_back.sv
// back part: bresenham stepping state and the result register
module lr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lr_pkg::cmd_t                  q_cmd,
	input  lr_pkg::q_status_t             q_stat,
	output logic                          q_pop,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [lr_pkg::COORD_BITS-1:0] pixel_x,
	output logic [lr_pkg::COORD_BITS-1:0] pixel_y,
	output logic                          pixel_valid,
	output logic                          last_pixel
);
	import lr_pkg::*;

	logic [COORD_BITS-1:0]     cur_x_q, cur_y_q, delta_x_q, delta_y_q, left_q;
	logic                      x_neg_q, y_neg_q, y_major_q, active_q;
	logic signed [DT_BITS-1:0] dec_q;
	logic                      rsp_valid_q;
	logic [COORD_BITS-1:0]     px_q, py_q;
	logic                      pv_q, last_q;

	logic                      load;
	logic [COORD_BITS-1:0]     major, minor, cmd_major, step_x, step_y, nx, ny, n_left;
	logic signed [DT_BITS-1:0] n_dec, minor2, major2;
	logic                      d_pos;

	assign load  = !rsp_valid_q || !rsp_stall;
	assign q_pop = load && !q_stat.empty;

	always_comb begin
		cmd_major = q_cmd.y_major ? q_cmd.delta_y : q_cmd.delta_x;
		major     = y_major_q ? delta_y_q : delta_x_q;
		minor     = y_major_q ? delta_x_q : delta_y_q;
		major2    = {2'b00, major, 1'b0};
		minor2    = {2'b00, minor, 1'b0};
		step_x    = x_neg_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
		step_y    = y_neg_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
		d_pos     = !dec_q[DT_BITS-1];
		nx        = cur_x_q;
		ny        = cur_y_q;
		if (y_major_q) begin
			ny = step_y;
			if (d_pos) nx = step_x;
		end else begin
			nx = step_x;
			if (d_pos) ny = step_y;
		end
		n_dec  = d_pos ? (dec_q + minor2 - major2) : (dec_q + minor2);
		n_left = left_q - 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) rsp_valid_q <= q_pop;
			if (q_pop) begin
				if (q_cmd.op == OP_START) active_q <= cmd_major != '0;
				else if (active_q)        active_q <= n_left != '0;
			end
		end
	end

	// line state and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_cmd.op == OP_START) begin
				cur_x_q   <= q_cmd.start_x;
				cur_y_q   <= q_cmd.start_y;
				delta_x_q <= q_cmd.delta_x;
				delta_y_q <= q_cmd.delta_y;
				x_neg_q   <= q_cmd.x_negative;
				y_neg_q   <= q_cmd.y_negative;
				y_major_q <= q_cmd.y_major;
				dec_q     <= q_cmd.decision;
				left_q    <= cmd_major;
				px_q      <= q_cmd.start_x;
				py_q      <= q_cmd.start_y;
				pv_q      <= 1'b1;
				last_q    <= cmd_major == '0;
			end else if (active_q) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				dec_q   <= n_dec;
				left_q  <= n_left;
				px_q    <= nx;
				py_q    <= ny;
				pv_q    <= 1'b1;
				last_q  <= n_left == '0;
			end else begin
				px_q   <= '0;
				py_q   <= '0;
				pv_q   <= 1'b0;
				last_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_valid = pv_q;
	assign last_pixel  = last_q;

endmodule
